FILE: hdl/pfa_pkg.sv
// Shared types and constants for the page-frame allocator.
// Action and status codes, stream packing widths and the controller status record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

  localparam int DEF_NUM_PAGES   = 16384;
  localparam int DEF_PAGE_SHIFT  = 12;
  localparam int DEF_COUNT_WIDTH = 8;

  localparam int ACT_W       = 3;
  localparam int PHYS_W      = 32;
  localparam int ADDR_W      = 26;
  localparam int STATUS_W    = 3;
  localparam int OUT_CNT_W   = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE  = 3'd1,
    ACT_SEED  = 3'd2,
    ACT_INC   = 3'd3,
    ACT_DEC   = 3'd4,
    ACT_GET   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_ADDR = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_LIMIT    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic clearing;
    logic idle;
    logic commit;
    logic released;
  } pfa_stat_t;

endpackage
`default_nettype wire

FILE: hdl/page_frame_allocator_refcount.sv
// Page-frame allocator with a LIFO free stack and a saturating reference count
// per page. One request is in work at a time: an alloc that finds a free page goes
// through a stack read, then a count read, then the commit of its result; every other
// action reads the count and then commits, and an alloc on an empty stack commits
// with neither read. Both memories have a registered read, and a result waiting in the
// output register delays only the commit of the next request. After reset the count
// table is cleared one entry per cycle, and requests are taken once the clear is done;
// configuration writes are taken at any time.
// Uses pfa_pkg, pfa_ctrl, pfa_ram.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_allocator_refcount
  import pfa_pkg::*;
#(
  parameter int NUM_PAGES   = DEF_NUM_PAGES,
  parameter int PAGE_SHIFT  = DEF_PAGE_SHIFT,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // action [2:0], phys_addr [34:3], zero [39:35]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // status [2:0], page_addr [28:3], count [36:29], page_released [37], zero [39:38]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [ADDR_W-1:0]      cfg_data
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int FW = $clog2(NUM_PAGES + 1);

  logic                   cnt_we;
  logic [PW-1:0]          cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic                   cnt_re;
  logic [PW-1:0]          cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic                   stk_we;
  logic [PW-1:0]          stk_waddr;
  logic [PW-1:0]          stk_wdata;
  logic                   stk_re;
  logic [PW-1:0]          stk_raddr;
  logic [PW-1:0]          stk_rdata;
  pfa_stat_t              stat;
  logic [FW-1:0]          stat_fill;

  pfa_ctrl #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_WIDTH(COUNT_WIDTH),
    .PW         (PW),
    .FW         (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_re    (cnt_re),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_re    (stk_re),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata),
    .stat      (stat),
    .stat_fill (stat_fill)
  );

  pfa_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_PAGES)
  ) u_count_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .re   (cnt_re),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  pfa_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_PAGES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  a_no_req_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_tready)
    else $error("request taken during count table clear");

  a_ready_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == stat.idle)
    else $error("request ready outside the idle state");

  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in work");

  a_release_pushes : assert property (@(posedge clk) disable iff (!rst_n)
    (stat.commit && stat.released) |=> (stat_fill == $past(stat_fill) + FW'(1)))
    else $error("released page did not grow the free stack");

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    stat_fill <= FW'(NUM_PAGES))
    else $error("free stack fill beyond its depth");

endmodule
`default_nettype wire

FILE: hdl/pfa_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the count table and the free-page stack. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pfa_ctrl.sv
// Sequencer and datapath of the allocator: reads, modifies and writes back the
// count table and the free stack, and holds the result register. Uses pfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ctrl
  import pfa_pkg::*;
#(
  parameter int NUM_PAGES   = DEF_NUM_PAGES,
  parameter int PAGE_SHIFT  = DEF_PAGE_SHIFT,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int PW          = $clog2(NUM_PAGES),
  parameter int FW          = $clog2(NUM_PAGES + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [ADDR_W-1:0]      cfg_data,
  output logic                        cnt_we,
  output logic      [PW-1:0]          cnt_waddr,
  output logic      [COUNT_WIDTH-1:0] cnt_wdata,
  output logic                        cnt_re,
  output logic      [PW-1:0]          cnt_raddr,
  input  wire logic [COUNT_WIDTH-1:0] cnt_rdata,
  output logic                        stk_we,
  output logic      [PW-1:0]          stk_waddr,
  output logic      [PW-1:0]          stk_wdata,
  output logic                        stk_re,
  output logic      [PW-1:0]          stk_raddr,
  input  wire logic [PW-1:0]          stk_rdata,
  output pfa_stat_t                   stat,
  output logic      [FW-1:0]          stat_fill
);

  localparam logic [63:0] TOP_ADDR = 64'(NUM_PAGES) << PAGE_SHIFT;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_POP   = 4'b0100,
    S_RD    = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           clr_r;
  logic [FW-1:0]           fill_r, fill_nxt;
  logic [ADDR_W-1:0]       low_r;
  action_t                 act_r;
  logic [PHYS_W-1:0]       addr_r;
  logic [PW-1:0]           pg_r;
  logic                    empty_r;
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;

  action_t                 in_act;
  logic [PHYS_W-1:0]       in_addr;
  logic [PW-1:0]           in_pg;
  logic                    in_acc;
  logic                    commit;
  logic                    range_bad;
  logic                    unaligned;
  logic                    can_push;
  logic [COUNT_WIDTH-1:0]  dec_cnt;
  logic [COUNT_WIDTH-1:0]  new_cnt;
  logic                    wr_cnt;
  logic                    push;
  logic                    pop;
  status_t                 res_status;
  logic [ADDR_W-1:0]       res_paddr;
  logic [COUNT_WIDTH-1:0]  res_cnt;
  logic                    res_rel;
  logic [63:0]             paddr_w;

  assign in_act  = action_t'(in_tdata[ACT_W-1:0]);
  assign in_addr = in_tdata[ACT_W+PHYS_W-1:ACT_W];
  assign in_pg   = PW'(in_addr >> PAGE_SHIFT);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign commit    = (state_r == S_RD) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  assign range_bad = (addr_r < PHYS_W'(low_r)) || (64'(addr_r) >= TOP_ADDR);
  assign unaligned = (addr_r[PAGE_SHIFT-1:0] != '0);
  assign can_push  = (fill_r < FW'(NUM_PAGES));
  assign dec_cnt   = cnt_rdata - COUNT_WIDTH'(1);
  assign paddr_w   = 64'(pg_r) << PAGE_SHIFT;

  always_comb begin
    res_status = ST_OK;
    res_paddr  = '0;
    res_cnt    = '0;
    res_rel    = 1'b0;
    new_cnt    = cnt_rdata;
    wr_cnt     = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    case (act_r)
      ACT_ALLOC: begin
        if (empty_r) begin
          res_status = ST_EMPTY;
        end else begin
          pop       = 1'b1;
          res_paddr = paddr_w[ADDR_W-1:0];
          res_cnt   = cnt_rdata;
        end
      end
      ACT_FREE, ACT_SEED: begin
        if (range_bad || unaligned) begin
          res_status = ST_BAD_ADDR;
        end else begin
          if (act_r == ACT_SEED || cnt_rdata == '0) begin
            new_cnt = '0;
          end else begin
            new_cnt = dec_cnt;
          end
          wr_cnt  = 1'b1;
          res_cnt = new_cnt;
          if (new_cnt == '0) begin
            if (can_push) begin
              push    = 1'b1;
              res_rel = 1'b1;
            end else begin
              res_status = ST_FULL;
            end
          end
        end
      end
      ACT_INC, ACT_DEC, ACT_GET: begin
        if (range_bad) begin
          res_status = ST_BAD_ADDR;
        end else begin
          if (act_r == ACT_INC) begin
            if (cnt_rdata == COUNT_MAX) begin
              res_status = ST_LIMIT;
            end else begin
              new_cnt = cnt_rdata + COUNT_WIDTH'(1);
              wr_cnt  = 1'b1;
            end
          end else if (act_r == ACT_DEC) begin
            if (cnt_rdata == '0) begin
              res_status = ST_LIMIT;
            end else begin
              new_cnt = dec_cnt;
              wr_cnt  = 1'b1;
            end
          end
          res_cnt = new_cnt;
        end
      end
      default: begin
        res_status = ST_BAD_ADDR;
      end
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    if (commit && push) begin
      fill_nxt = fill_r + FW'(1);
    end else if (commit && pop) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = pg_r;
    cnt_wdata = new_cnt;
    cnt_re    = 1'b0;
    cnt_raddr = in_pg;
    stk_we    = commit && push;
    stk_waddr = fill_r[PW-1:0];
    stk_wdata = pg_r;
    stk_re    = 1'b0;
    stk_raddr = PW'(fill_r - FW'(1));
    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
      end
      S_IDLE: begin
        cnt_re = in_acc && (in_act != ACT_ALLOC);
        stk_re = in_acc && (in_act == ACT_ALLOC) && (fill_r != '0);
      end
      S_POP: begin
        cnt_re    = 1'b1;
        cnt_raddr = stk_rdata;
      end
      S_RD: begin
        cnt_we = commit && wr_cnt;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == PW'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_act == ACT_ALLOC && fill_r != '0) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_POP: begin
        state_nxt = S_RD;
      end
      S_RD: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fill_r      <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + PW'(1);
      end
      if (cfg_valid) begin
        low_r <= cfg_data;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_act;
      addr_r  <= in_addr;
      pg_r    <= in_pg;
      empty_r <= (fill_r == '0);
    end else if (state_r == S_POP) begin
      pg_r <= stk_rdata;
    end
    if (commit) begin
      out_data_r <= {
        {(OUT_TDATA_W - STATUS_W - ADDR_W - OUT_CNT_W - 1){1'b0}},
        res_rel, OUT_CNT_W'(res_cnt), res_paddr, res_status
      };
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.idle     = (state_r == S_IDLE);
  assign stat.commit   = commit;
  assign stat.released = res_rel;
  assign stat_fill     = fill_r;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for page_frame_allocator_refcount: stream requests in,
// results out, predicted by a scoreboard class that keeps the free stack and counts.
// Depends on pfa_pkg and the page_frame_allocator_refcount RTL.
`timescale 1ns / 1ps
module tb_top;
  import pfa_pkg::*;

  localparam int PAGES = DEF_NUM_PAGES;
  localparam int PG_SHIFT = DEF_PAGE_SHIFT;
  localparam int PG_W = $clog2(DEF_NUM_PAGES);
  localparam int COUNT_MAX = (1 << DEF_COUNT_WIDTH) - 1;
  localparam longint unsigned MEM_TOP = longint'(DEF_NUM_PAGES) << DEF_PAGE_SHIFT;
  localparam logic [ACT_W-1:0] ACT_RESERVED_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RESERVED_B = 3'd7;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    status_t              status;
    logic [ADDR_W-1:0]    page_addr;
    logic [OUT_CNT_W-1:0] count;
    logic                 released;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [OUT_CNT_W-1:0] page_refs[PAGES];
    logic [PG_W-1:0]      free_pages[PAGES];
    int unsigned          free_depth;
    logic [ADDR_W-1:0]    low_limit;
    int                   last_alloc_page;
    alloc_result_t        expected_q[$];
    int unsigned          mismatches;
    int unsigned          results_seen;

    function new();
      foreach (page_refs[i]) page_refs[i] = '0;
      free_depth = 0;
      low_limit = '0;
      last_alloc_page = -1;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit push_page(logic [PG_W-1:0] pg);
      if (free_depth >= PAGES) return 1'b0;
      free_pages[free_depth] = pg;
      free_depth++;
      return 1'b1;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [PHYS_W-1:0] addr);
      alloc_result_t r;
      logic [PG_W-1:0] pg;
      bit in_range;
      r.status = ST_OK;
      r.page_addr = '0;
      r.count = '0;
      r.released = 1'b0;
      in_range = (longint'(addr) >= longint'(low_limit)) && (longint'(addr) < MEM_TOP);
      pg = addr[PG_SHIFT +: PG_W];
      if (act == ACT_ALLOC) begin
        last_alloc_page = -1;
        if (free_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_depth--;
          pg = free_pages[free_depth];
          r.page_addr = ADDR_W'(pg) << PG_SHIFT;
          r.count = page_refs[pg];
          last_alloc_page = int'(pg);
        end
      end else if (act > ACT_GET || !in_range ||
                   ((act == ACT_FREE || act == ACT_SEED) && addr[PG_SHIFT-1:0] != '0)) begin
        r.status = ST_BAD_ADDR;
      end else begin
        case (act)
          ACT_FREE: begin
            if (page_refs[pg] != '0) page_refs[pg]--;
            if (page_refs[pg] == '0) begin
              if (push_page(pg)) r.released = 1'b1;
              else r.status = ST_FULL;
            end
          end
          ACT_SEED: begin
            page_refs[pg] = '0;
            if (push_page(pg)) r.released = 1'b1;
            else r.status = ST_FULL;
          end
          ACT_INC: begin
            if (page_refs[pg] == COUNT_MAX) r.status = ST_LIMIT;
            else page_refs[pg]++;
          end
          ACT_DEC: begin
            if (page_refs[pg] == '0) r.status = ST_LIMIT;
            else page_refs[pg]--;
          end
          default: ;
        endcase
        r.count = page_refs[pg];
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      alloc_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with nothing expected: %h", $time, d);
        return;
      end
      e = expected_q.pop_front();
      if (d[STATUS_W-1:0] !== e.status || d[STATUS_W +: ADDR_W] !== e.page_addr ||
          d[STATUS_W+ADDR_W +: OUT_CNT_W] !== e.count ||
          d[STATUS_W+ADDR_W+OUT_CNT_W] !== e.released) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d expected status %0d addr %h count %0d rel %0d, got %0d %h %0d %0d",
                   $time, results_seen, e.status, e.page_addr, e.count, e.released,
                   d[STATUS_W-1:0], d[STATUS_W +: ADDR_W], d[STATUS_W+ADDR_W +: OUT_CNT_W],
                   d[STATUS_W+ADDR_W+OUT_CNT_W]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ADDR_W-1:0] cfg_data = '0;

  alloc_scoreboard sb;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_off_req = 1'b0;
  int hot_base = 0;

  always #4 clk = ~clk;

  page_frame_allocator_refcount dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PHYS_W-1:0] hot_addr(bit aligned);
    int unsigned pg;
    logic [PHYS_W-1:0] a;
    pg = hot_base + $urandom_range(0, 7);
    if (pg > PAGES - 1) pg = PAGES - 1;
    a = PHYS_W'(pg) << PG_SHIFT;
    if (!aligned) a[PG_SHIFT-1:0] = PG_SHIFT'($urandom);
    return a;
  endfunction

  function automatic logic [PHYS_W-1:0] rand_addr();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return hot_addr($urandom_range(0, 3) != 0);
    if (sel < 90) begin
      case ($urandom_range(0, 4))
        0: return PHYS_W'(sb.low_limit) - 1;
        1: return PHYS_W'(sb.low_limit);
        2: return PHYS_W'(MEM_TOP - 1);
        3: return PHYS_W'(MEM_TOP);
        default: return PHYS_W'(MEM_TOP) - (PHYS_W'(1) << PG_SHIFT);
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [ACT_W-1:0] rand_action();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return ACT_ALLOC;
    if (sel < 35) return ACT_FREE;
    if (sel < 45) return ACT_SEED;
    if (sel < 70) return ACT_INC;
    if (sel < 85) return ACT_DEC;
    if (sel < 95) return ACT_GET;
    return $urandom_range(0, 1) ? ACT_RESERVED_A : ACT_RESERVED_B;
  endfunction

  task automatic send_req(logic [ACT_W-1:0] act, logic [PHYS_W-1:0] addr);
    @(negedge clk);
    in_tdata <= {{(IN_TDATA_W - ACT_W - PHYS_W){1'b0}}, addr, act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, addr);
    if (!tx_steady && $urandom_range(0, 2) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (pick_gap() - 1) @(negedge clk);
    end
  endtask

  task automatic set_low_limit(logic [ADDR_W-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.low_limit = v;
    hot_base = (int'(v) + (1 << PG_SHIFT) - 1) >> PG_SHIFT;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic page_lifecycle();
    int n;
    logic [PHYS_W-1:0] a;
    send_req(ACT_ALLOC, $urandom);
    if (sb.last_alloc_page < 0) begin
      send_req(ACT_SEED, hot_addr(1'b1));
      return;
    end
    a = PHYS_W'(sb.last_alloc_page) << PG_SHIFT;
    n = $urandom_range(0, 4);
    repeat (n) send_req(ACT_INC, a | PHYS_W'($urandom_range(0, (1 << PG_SHIFT) - 1)));
    if ($urandom_range(0, 1)) send_req(ACT_GET, a);
    repeat (n + 1) send_req(ACT_FREE, a);
  endtask

  task automatic random_steps(int steps);
    int unsigned sel;
    repeat (steps) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) page_lifecycle();
      else if (sel < 85) send_req(rand_action(), rand_addr());
      else send_req(ACT_W'($urandom), $urandom);
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = pick_gap() - 1;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [PHYS_W-1:0] sat_addr;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: page 0 sits below the limit, the top page is the last legal one.
    set_low_limit(ADDR_W'(1) << PG_SHIFT);
    send_req(ACT_ALLOC, 32'h0);
    send_req(ACT_GET, 32'h0000_0000);
    send_req(ACT_GET, 32'h0000_1000);
    send_req(ACT_SEED, 32'h0000_1000);
    send_req(ACT_SEED, 32'h03FF_F000);
    send_req(ACT_FREE, 32'h0000_2001);
    send_req(ACT_FREE, 32'h0400_0000);
    send_req(ACT_GET, 32'hFFFF_FFFF);
    send_req(ACT_INC, 32'h0000_1FFF);
    send_req(ACT_INC, 32'h0000_1000);
    send_req(ACT_GET, 32'h0000_1ABC);
    send_req(ACT_DEC, 32'h0000_1000);
    send_req(ACT_FREE, 32'h0000_1000);
    send_req(ACT_DEC, 32'h0000_1000);
    send_req(ACT_FREE, 32'h0000_2000);
    send_req(ACT_INC, 32'h03FF_FFFF);
    send_req(ACT_GET, 32'h03FF_FFFF);
    send_req(ACT_RESERVED_A, 32'h0000_3000);
    send_req(ACT_RESERVED_B, 32'hFFFF_FFFF);
    repeat (5) send_req(ACT_ALLOC, $urandom);

    // Random traffic with a counter driven into saturation.
    set_low_limit('0);
    random_steps(40);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    sat_addr = hot_addr(1'b1);
    repeat (COUNT_MAX + 4) send_req(ACT_INC, sat_addr);
    send_req(ACT_GET, sat_addr);
    send_req(ACT_DEC, sat_addr);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // The result side stalls for a long stretch while requests keep coming.
    hold_off_req = 1'b1;
    repeat (40) send_req(rand_action(), rand_addr());

    set_low_limit('1);
    repeat (50) send_req(rand_action(), rand_addr());

    set_low_limit(ADDR_W'(32'h0200_0800));
    random_steps(50);

    // Counts on a few fixed pages, then twenty allocs are taken from the free stack.
    set_low_limit('0);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_req(ACT_SEED, 32'h0000_5000);
    send_req(ACT_FREE, 32'h0000_6000);
    send_req(ACT_INC, 32'h0000_7000);
    send_req(ACT_INC, 32'h0000_7000);
    send_req(ACT_FREE, 32'h0000_7000);
    send_req(ACT_FREE, 32'h0000_7000);
    send_req(ACT_GET, 32'h0000_7000);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (20) send_req(ACT_ALLOC, $urandom);

    set_low_limit(ADDR_W'($urandom_range(0, 32'h0100_0000)));
    random_steps(40);

    @(negedge clk);
    in_tvalid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && sb.pending() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
